// ===== rtl/lsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared types, register indexes, mode codes and timing defaults for the
// LCD scanline and mode timing block.
// ----------------------------------------------------------------------------
package lsmt_pkg;

    // Default timing of one frame
    localparam int LINE_CYCLES_DEF     = 456;
    localparam int LAST_LINE_DEF       = 153;
    localparam int VISIBLE_LINES_DEF   = 144;
    localparam int OAM_CYCLES_DEF      = 80;
    localparam int TRANSFER_CYCLES_DEF = 172;

    // Field widths
    localparam int LINE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int ELAPSED_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LCD_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HBLANK_IRQ_EN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VBLANK_IRQ_EN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OAM_IRQ_EN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_IRQ_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_LINE  = 3'd5;

    // Display modes
    localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OAM      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

    typedef struct packed {
        logic              lcd_enable;
        logic              hblank_irq_en;
        logic              vblank_irq_en;
        logic              oam_irq_en;
        logic              match_irq_en;
        logic [LINE_W-1:0] compare_line;
    } cfg_t;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [MODE_W-1:0] mode;
        logic              match_flag;
        logic              stat_irq;
        logic              vblank_irq;
        logic              draw_line;
    } result_t;

endpackage

// ===== rtl/lsmt_cfg.sv =====
// ----------------------------------------------------------------------------
// lsmt_cfg
// Control register file: decodes writes by index and holds the settings.
// ----------------------------------------------------------------------------
module lsmt_cfg
    import lsmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LCD_ENABLE:    cfg_next.lcd_enable    = cfg_wdata[0];
                REG_HBLANK_IRQ_EN: cfg_next.hblank_irq_en = cfg_wdata[0];
                REG_VBLANK_IRQ_EN: cfg_next.vblank_irq_en = cfg_wdata[0];
                REG_OAM_IRQ_EN:    cfg_next.oam_irq_en    = cfg_wdata[0];
                REG_MATCH_IRQ_EN:  cfg_next.match_irq_en  = cfg_wdata[0];
                REG_COMPARE_LINE:  cfg_next.compare_line  = cfg_wdata[LINE_W-1:0];
                default:           cfg_next = cfg_reg; // drop unknown index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lsmt_core.sv =====
// ----------------------------------------------------------------------------
// lsmt_core
// Timing state (cycle counter, line, mode, match) and the single-pass step
// logic that computes one result word and the next state.
// ----------------------------------------------------------------------------
module lsmt_core
    import lsmt_pkg::*;
#(
    parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
    parameter int LAST_LINE       = LAST_LINE_DEF,
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [ELAPSED_W-1:0] elapsed,
    input  cfg_t                 cfg,
    output result_t              result
);

    localparam int CNT_W  = $clog2(LINE_CYCLES + 1);
    localparam int B2     = LINE_CYCLES - OAM_CYCLES;
    localparam int B3     = B2 - TRANSFER_CYCLES;
    localparam int B3_MAG = (B3 < 0) ? -B3 : B3;
    localparam int MAG_A  = (LINE_CYCLES > 255) ? LINE_CYCLES : 255;
    localparam int MAG    = (MAG_A > B3_MAG) ? MAG_A : B3_MAG;
    localparam int SW     = $clog2(MAG + 1) + 1;

    localparam logic signed [SW-1:0] B2_S      = SW'(B2);
    localparam logic signed [SW-1:0] B3_S      = SW'(B3);
    localparam logic [CNT_W-1:0]     CNT_LOAD  = CNT_W'(LINE_CYCLES);
    localparam logic [LINE_W-1:0]    VIS_LINE  = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W:0]      LAST_LINE9 = (LINE_W + 1)'(LAST_LINE);

    logic [CNT_W-1:0]  cycle_count_reg, cycle_count_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic              match_reg, match_next;

    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] diff_s;
    logic                 wrap;
    logic [LINE_W:0]      line_inc;
    logic                 beyond_last;
    logic [LINE_W-1:0]    line_adv;
    logic [MODE_W-1:0]    mode_sel;
    logic                 mode_en;
    logic                 match_now;
    logic                 stat;

    assign cnt_s       = signed'(SW'({1'b0, cycle_count_reg}));
    assign diff_s      = cnt_s - signed'(SW'({1'b0, elapsed}));
    assign wrap        = (diff_s <= signed'(SW'(0)));
    assign line_inc    = {1'b0, line_reg} + (LINE_W + 1)'(1);
    assign beyond_last = (line_inc > LAST_LINE9);
    assign line_adv    = beyond_last ? '0 : line_inc[LINE_W-1:0];
    assign match_now   = (line_reg == cfg.compare_line);

    always_comb
    begin
        priority if (line_reg >= VIS_LINE)
        begin
            mode_sel = MODE_VBLANK;
            mode_en  = cfg.vblank_irq_en;
        end
        else if (cnt_s >= B2_S)
        begin
            mode_sel = MODE_OAM;
            mode_en  = cfg.oam_irq_en;
        end
        else if (cnt_s >= B3_S)
        begin
            mode_sel = MODE_TRANSFER;
            mode_en  = 1'b0;
        end
        else
        begin
            mode_sel = MODE_HBLANK;
            mode_en  = cfg.hblank_irq_en;
        end
    end

    assign stat = ((mode_sel != mode_reg) && mode_en) || (match_now && cfg.match_irq_en);

    always_comb
    begin
        if (!cfg.lcd_enable)
        begin
            cycle_count_next  = CNT_LOAD;
            line_next         = '0;
            mode_next         = MODE_VBLANK;
            match_next        = match_reg;
            result.stat_irq   = 1'b0;
            result.vblank_irq = 1'b0;
            result.draw_line  = 1'b0;
        end
        else
        begin
            mode_next        = mode_sel;
            match_next       = match_now;
            result.stat_irq  = stat;
            cycle_count_next = wrap ? CNT_LOAD : diff_s[CNT_W-1:0];
            line_next        = wrap ? line_adv : line_reg;
            result.vblank_irq = wrap && !beyond_last && (line_adv >= VIS_LINE);
            result.draw_line  = wrap && !beyond_last && (line_adv < VIS_LINE);
        end
        result.line       = line_next;
        result.mode       = mode_next;
        result.match_flag = match_next;
    end

    // Commit the state only when an item passes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg <= CNT_LOAD;
            line_reg        <= '0;
            mode_reg        <= MODE_HBLANK;
            match_reg       <= 1'b0;
        end
        else if (step)
        begin
            cycle_count_reg <= cycle_count_next;
            line_reg        <= line_next;
            mode_reg        <= mode_next;
            match_reg       <= match_next;
        end
    end

endmodule

// ===== rtl/lcd_scanline_mode_timing.sv =====
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing
// Scanline and display mode timing of a handheld LCD controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / elapsed_cycles): each word reports
//   how much CPU time has passed. Output channel (out_valid /
//   out_stall / line, mode, match_flag, stat_irq, vblank_irq, draw_line):
//   exactly one result word per input word, in order.
//   Config port (cfg_we / cfg_index / cfg_wdata): write only while idle.
//   Path: a word accepted into the input stage is registered there,
//   stepped through the timing logic and then loaded into the output
//   register, where its result becomes visible.
//   Throughput: one word per cycle while out_stall is low; the counter/line
//   update is one compare-and-subtract pass between input and output stages.
//   Reset: the counter loads a full line, line and mode clear, all config
//   registers clear (display off), both pipeline stages empty.
//   Stall: while out_stall holds a result, the input stage still takes one
//   more word; in_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing
    import lsmt_pkg::*;
#(
    parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
    parameter int LAST_LINE       = LAST_LINE_DEF,
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ELAPSED_W-1:0]  elapsed_cycles,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LINE_W-1:0]     line,
    output logic [MODE_W-1:0]     mode,
    output logic                  match_flag,
    output logic                  stat_irq,
    output logic                  vblank_irq,
    output logic                  draw_line
);

    cfg_t    cfg;
    result_t step_result;

    logic                 in_valid_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic                 out_valid_reg;
    result_t              result_reg;

    logic advance;
    logic take_in;

    // Move a word forward when the output slot is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    // The input slot frees up when empty or when its word advances
    assign in_stall = in_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    lsmt_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lsmt_core
    #(
        .LINE_CYCLES     (LINE_CYCLES),
        .LAST_LINE       (LAST_LINE),
        .VISIBLE_LINES   (VISIBLE_LINES),
        .OAM_CYCLES      (OAM_CYCLES),
        .TRANSFER_CYCLES (TRANSFER_CYCLES)
    )
    u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .elapsed (elapsed_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input stage: hold the word until the step logic consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            elapsed_reg <= elapsed_cycles;
        end
    end

    // Output stage: load on advance, drop once the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line       = result_reg.line;
    assign mode       = result_reg.mode;
    assign match_flag = result_reg.match_flag;
    assign stat_irq   = result_reg.stat_irq;
    assign vblank_irq = result_reg.vblank_irq;
    assign draw_line  = result_reg.draw_line;

`ifndef SYNTHESIS
    // Input stalls only when both stages hold words and the receiver stalls
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    // A line start is either vblank or visible, never both
    a_vbl_draw_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(vblank_irq && draw_line))
        else $error("vblank and draw flagged together");

    // Draw requests only name visible lines
    a_draw_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && draw_line) |-> (line < LINE_W'(VISIBLE_LINES)))
        else $error("draw flagged outside visible lines");

    // Line never passes the last line of the frame
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, line} <= (LINE_W + 1)'(LAST_LINE)))
        else $error("line beyond last line");
`endif

endmodule
